FILE: rtl/core/pwm_frequency_duty_meter_unit_defines.svh
// Assertion macros shared by the PWM frequency and duty meter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PWM_FREQUENCY_DUTY_METER_UNIT_DEFINES_SVH
`define PWM_FREQUENCY_DUTY_METER_UNIT_DEFINES_SVH

// Concurrent check, sampled on the rising clock edge, off during reset.
`define PWMFDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define PWMFDM_NEVER(label, clk, rst, cond, msg) \
   `PWMFDM_ASSERT(label, clk, rst, !(cond), msg)

`endif

FILE: rtl/core/pwmfdm_pkg.sv
// Package for the PWM frequency and duty meter: widths, constants, queue word type
// and the output clamp. No dependencies.
package pwmfdm_pkg;

   localparam int CNT_W    = 32;            // tick counter width, 16..48
   localparam int RATE_W   = 27;
   localparam int FREQ_W   = 8;
   localparam int DUTY_W   = 7;
   localparam int OUT_W    = 32;
   localparam int TOTAL_W  = CNT_W + 1;
   localparam int PROD_W   = CNT_W + DUTY_W;
   localparam int REM_W    = (CNT_W + 9 > RATE_W) ? CNT_W + 9 : RATE_W;
   localparam int QUO_W    = FREQ_W + 1;
   localparam int STEP_W   = $clog2(QUO_W);
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = Q_PTR_W + 1;

   localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
   localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(12000000);
   localparam logic [FREQ_W-1:0] FREQ_MAX    = 8'd255;
   localparam logic [DUTY_W-1:0] PERCENT     = 7'd100;
   localparam logic [OUT_W-1:0]  OUT_MAX     = 32'hFFFF_FFFF;
   localparam logic [STEP_W-1:0] FREQ_TOP    = STEP_W'(FREQ_W);
   localparam logic [STEP_W-1:0] DUTY_TOP    = STEP_W'(DUTY_W - 1);

   // One recorded edge as it travels from the front to the back.
   typedef struct packed {
      logic [CNT_W-1:0] high_time;
      logic [CNT_W-1:0] low_time;
      logic             have_high;
      logic             have_low;
   } meas_type;

   function automatic logic [OUT_W-1:0] clamp_out(input logic [CNT_W-1:0] v);
      logic [CNT_W:0] ext;
      ext = {1'b0, v};
      if (ext > (CNT_W + 1)'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return OUT_W'(v);
   endfunction

endpackage

FILE: rtl/core/pwmfdm_front.sv
// Front part: edge detection, saturating tick counter and phase recording.
// Depends on pwmfdm_pkg; pushes one meas_type word per recorded edge.
module pwmfdm_front
   import pwmfdm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  logic     level,
   output logic     q_push,
   output meas_type q_word
);

   logic             prev_ff, prev_in;
   logic             started_ff, started_in;
   logic             awaiting_ff, awaiting_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] high_ff, high_in;
   logic [CNT_W-1:0] low_ff, low_in;
   logic             have_high_ff, have_high_in;
   logic             have_low_ff, have_low_in;

   logic             rise, fall;
   logic [CNT_W-1:0] cnt_inc;

   assign rise    = level & ~prev_ff;
   assign fall    = ~level & prev_ff;
   assign cnt_inc = (cnt_ff < CNT_MAX) ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_comb begin
      prev_in      = prev_ff;
      started_in   = started_ff;
      awaiting_in  = awaiting_ff;
      cnt_in       = cnt_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      have_high_in = have_high_ff;
      have_low_in  = have_low_ff;
      q_push       = 1'b0;
      if (accept) begin
         prev_in = level;
         if (!started_ff) begin
            if (rise) begin
               started_in  = 1'b1;
               awaiting_in = 1'b1;
               cnt_in      = '0;
            end
         end else if (fall && awaiting_ff) begin
            high_in      = cnt_inc;
            have_high_in = 1'b1;
            awaiting_in  = 1'b0;
            cnt_in       = '0;
            q_push       = 1'b1;
         end else if (rise && !awaiting_ff) begin
            low_in      = cnt_inc;
            have_low_in = 1'b1;
            awaiting_in = 1'b1;
            cnt_in      = '0;
            q_push      = 1'b1;
         end else begin
            cnt_in = cnt_inc;
         end
      end
   end

   // The word carries the updated times so the back sees this edge's view.
   assign q_word = '{high_time: high_in, low_time: low_in,
                     have_high: have_high_in, have_low: have_low_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b1;
         started_ff   <= 1'b0;
         awaiting_ff  <= 1'b0;
         cnt_ff       <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         have_high_ff <= 1'b0;
         have_low_ff  <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         started_ff   <= started_in;
         awaiting_ff  <= awaiting_in;
         cnt_ff       <= cnt_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         have_high_ff <= have_high_in;
         have_low_ff  <= have_low_in;
      end
   end

endmodule

FILE: rtl/core/pwmfdm_queue.sv
// Short flip-flop queue of measurement words between front and back.
// Depends on pwmfdm_pkg.
module pwmfdm_queue
   import pwmfdm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  meas_type push_word,
   input  logic     pop,
   output meas_type pop_word,
   output logic     empty,
   output logic     full
);

   meas_type             slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign empty    = (count_ff == Q_CNT_W'(0));
   assign full     = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/pwmfdm_back.sv
// Back part: serial divider for frequency and duty plus the one-word result register.
// Depends on pwmfdm_pkg and the assertion macros header.
`include "pwm_frequency_duty_meter_unit_defines.svh"

module pwmfdm_back
   import pwmfdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [RATE_W-1:0] tick_rate,
   input  logic              q_empty,
   input  meas_type          q_word,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [FREQ_W-1:0] freq_hz,
   output logic [DUTY_W-1:0] duty_percent,
   output logic [OUT_W-1:0]  high_ticks,
   output logic [OUT_W-1:0]  low_ticks,
   output logic              measure_valid
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FREQ,
      ST_DUTY,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   meas_type             job_ff, job_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;
   logic                 out_vld_ff, out_vld_in;
   logic [FREQ_W-1:0]    o_freq_ff, o_freq_in;
   logic [DUTY_W-1:0]    o_duty_ff, o_duty_in;
   logic [OUT_W-1:0]     o_high_ff, o_high_in;
   logic [OUT_W-1:0]     o_low_ff, o_low_in;
   logic                 o_valid_ff, o_valid_in;

   logic [REM_W-1:0]     trial;
   logic                 ge;
   logic [QUO_W-1:0]     quo_step;
   logic                 job_valid;

   // One restoring step: divisor shifted to the current quotient bit.
   assign trial     = REM_W'(total_ff) << step_ff;
   assign ge        = (rem_ff >= trial);
   assign job_valid = job_ff.have_high & job_ff.have_low;

   always_comb begin
      quo_step = quo_ff;
      if (ge) begin
         quo_step[step_ff] = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      total_in   = total_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      freq_in    = freq_ff;
      duty_in    = duty_ff;
      out_vld_in = out_vld_ff & ~rsp_pop;
      o_freq_in  = o_freq_ff;
      o_duty_in  = o_duty_ff;
      o_high_in  = o_high_ff;
      o_low_in   = o_low_ff;
      o_valid_in = o_valid_ff;
      q_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_word;
               total_in = TOTAL_W'(q_word.high_time) + TOTAL_W'(q_word.low_time);
               prod_in  = PROD_W'(q_word.high_time) * PROD_W'(PERCENT);
               rem_in   = REM_W'(tick_rate);
               quo_in   = '0;
               step_in  = FREQ_TOP;
               freq_in  = '0;
               duty_in  = '0;
               state_in = (q_word.have_high && q_word.have_low) ? ST_FREQ : ST_DONE;
            end
         end
         ST_FREQ: begin
            if (ge) begin
               rem_in = rem_ff - trial;
            end
            quo_in = quo_step;
            if (ge && step_ff == FREQ_TOP) begin
               // quotient reaches 256: saturate
               freq_in = FREQ_MAX;
            end else if (step_ff == '0) begin
               freq_in = quo_step[FREQ_W-1:0];
            end
            if ((ge && step_ff == FREQ_TOP) || step_ff == '0) begin
               rem_in   = REM_W'(prod_ff);
               quo_in   = '0;
               step_in  = DUTY_TOP;
               state_in = ST_DUTY;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DUTY: begin
            if (ge) begin
               rem_in = rem_ff - trial;
            end
            quo_in = quo_step;
            if (step_ff == '0) begin
               duty_in  = quo_step[DUTY_W-1:0];
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_pop) begin
               out_vld_in = 1'b1;
               o_freq_in  = freq_ff;
               o_duty_in  = duty_ff;
               o_high_in  = job_ff.have_high ? clamp_out(job_ff.high_time) : '0;
               o_low_in   = job_ff.have_low ? clamp_out(job_ff.low_time) : '0;
               o_valid_in = job_valid;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         job_ff     <= job_in;
         total_ff   <= total_in;
         prod_ff    <= prod_in;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         step_ff    <= step_in;
         freq_ff    <= freq_in;
         duty_ff    <= duty_in;
         o_freq_ff  <= o_freq_in;
         o_duty_ff  <= o_duty_in;
         o_high_ff  <= o_high_in;
         o_low_ff   <= o_low_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_empty     = ~out_vld_ff;
   assign freq_hz       = o_freq_ff;
   assign duty_percent  = o_duty_ff;
   assign high_ticks    = o_high_ff;
   assign low_ticks     = o_low_ff;
   assign measure_valid = o_valid_ff;

   `PWMFDM_NEVER(a_duty_range, clock, reset, out_vld_ff && o_duty_ff > PERCENT, "duty above 100")
   `PWMFDM_NEVER(a_invalid_zero, clock, reset,
                 out_vld_ff && !o_valid_ff && (o_freq_ff != '0 || o_duty_ff != '0),
                 "freq or duty nonzero on an incomplete measurement")
   `PWMFDM_ASSERT(a_pop_has_word, clock, reset, q_pop |-> !q_empty, "queue read while empty")
   `PWMFDM_ASSERT(a_done_loads, clock, reset,
                  (state_ff == ST_DONE && (!out_vld_ff || rsp_pop)) |=> out_vld_ff,
                  "finished word not loaded into result register")

endmodule

FILE: rtl/core/pwm_frequency_duty_meter_unit.sv
// PWM frequency and duty meter, top level.
// Usage: one signal sample is pushed per timer tick on req_ (push/full).
// Recorded edges give result words on rsp_ (empty/pop); other samples give none.
// The first rising edge after reset only starts counting; each later falling
// edge records the high time, each rising edge the low time.
// The front takes one sample per cycle while req_full is low; recorded edges
// wait in a 4-word queue. The back works one word at a time: pop, 9 restoring
// divide steps for frequency and 7 for duty, then store; frequency division ends
// at a saturating first step, and an incomplete measurement skips the division.
// The sequential divider sets the sustained rate of recorded edges; samples
// without an edge are taken every cycle while req_full is low. With the back
// idle, rsp_empty goes low once an edge has passed queue, pop, divide and store.
// When the receiver does not pop, the result register holds, the back waits,
// the queue fills and req_full rises. csr_ writes set the tick rate; the user
// must make them only while the block is idle; the block does not enforce this.
// Reset (synchronous, active high) clears queue, counters and the result valid flag,
// and sets the tick rate to 12000000.
// Depends on pwmfdm_pkg, pwmfdm_front, pwmfdm_queue, pwmfdm_back.
module pwm_frequency_duty_meter_unit
   import pwmfdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_signal_level,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [FREQ_W-1:0] rsp_freq_hz,
   output logic [DUTY_W-1:0] rsp_duty_percent,
   output logic [OUT_W-1:0]  rsp_high_ticks,
   output logic [OUT_W-1:0]  rsp_low_ticks,
   output logic              rsp_measure_valid,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_wdata
);

   logic [RATE_W-1:0] rate_ff;
   logic              accept;
   logic              q_push, q_pop, q_empty, q_full;
   meas_type          push_word, pop_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   pwmfdm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .level  (req_signal_level),
      .q_push (q_push),
      .q_word (push_word)
   );

   pwmfdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   pwmfdm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tick_rate     (rate_ff),
      .q_empty       (q_empty),
      .q_word        (pop_word),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .freq_hz       (rsp_freq_hz),
      .duty_percent  (rsp_duty_percent),
      .high_ticks    (rsp_high_ticks),
      .low_ticks     (rsp_low_ticks),
      .measure_valid (rsp_measure_valid)
   );

endmodule
